>>> design/lkvt_pkg.sv
package lkvt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    // request codes carried in req_type
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_GET  = 2'd1,
        OP_DEL  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_BITS-1:0]   req_key;
        logic [VALUE_BITS-1:0] req_value;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
        logic                  full_error;
        logic [CNT_BITS-1:0]   entry_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

endpackage

>>> design/linear_key_value_table.sv
// Key-value table of up to 16 entries kept in insertion order in one
// synchronous RAM (one write port, one registered read port). Each request
// item (set, get or delete) is taken only while the block is idle and gives
// exactly one response item. A request scans the stored keys oldest first, one
// RAM read per cycle, and stops at the first match. A delete that hits then moves
// every later entry down one place through the same RAM, one entry per cycle.
// A set of a new key into a full table is dropped and flagged with full_error.
// The response sits in an output register, so the next request may enter while
// the previous response still waits to be taken.
module linear_key_value_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  lkvt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output lkvt_pkg::rsp_t rsp
);
    import lkvt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_RESOLVE = 5'b00100,
        ST_SHIFT   = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [CNT_BITS-1:0]   used_count_reg, used_count_next;
    logic [CNT_BITS-1:0]   issue_cnt_reg, issue_cnt_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   pos_reg, pos_next;
    logic [VALUE_BITS-1:0] found_value_reg, found_value_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  res_full_reg, res_full_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    entry_t                mem [TABLE_DEPTH];
    entry_t                rd_data_reg;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    entry_t                wr_data;

    logic                  scan_issue;
    logic                  match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign scan_issue = issue_cnt_reg < used_count_reg;
    assign match      = cmp_valid_reg && (rd_data_reg.key == req_reg.req_key);
    assign rd_addr    = issue_cnt_reg[IDX_BITS-1:0];

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        used_count_next  = used_count_reg;
        issue_cnt_next   = issue_cnt_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        pos_next         = pos_reg;
        found_value_next = found_value_reg;
        res_value_next   = res_value_reg;
        res_full_next    = res_full_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    issue_cnt_next = '0;
                    cmp_valid_next = 1'b0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    found_next       = 1'b1;
                    pos_next         = cmp_idx_reg;
                    found_value_next = rd_data_reg.value;
                    cmp_valid_next   = 1'b0;
                    state_next       = ST_RESOLVE;
                end
                else if (!scan_issue && !cmp_valid_reg)
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    // keep one read in flight ahead of the compare
                    rd_en          = scan_issue;
                    cmp_valid_next = scan_issue;
                    cmp_idx_next   = issue_cnt_reg[IDX_BITS-1:0];
                    if (scan_issue)
                    begin
                        issue_cnt_next = issue_cnt_reg + CNT_BITS'(1);
                    end
                end
            end

            ST_RESOLVE:
            begin
                res_value_next = '0;
                res_full_next  = 1'b0;
                state_next     = ST_FINISH;
                unique case (req_reg.req_type)
                    OP_SET:
                    begin
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = pos_reg;
                            wr_data = '{key: req_reg.req_key, value: req_reg.req_value};
                        end
                        else if (used_count_reg == CNT_BITS'(TABLE_DEPTH))
                        begin
                            res_full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = used_count_reg[IDX_BITS-1:0];
                            wr_data         = '{key: req_reg.req_key,
                                                value: req_reg.req_value};
                            used_count_next = used_count_reg + CNT_BITS'(1);
                        end
                    end
                    OP_GET:
                    begin
                        if (found_reg)
                        begin
                            res_value_next = found_value_reg;
                        end
                    end
                    OP_DEL:
                    begin
                        if (found_reg)
                        begin
                            issue_cnt_next = CNT_BITS'(pos_reg) + CNT_BITS'(1);
                            cmp_valid_next = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_SHIFT:
            begin
                // read entry j+1, write it back at j on the next cycle
                rd_en          = scan_issue;
                cmp_valid_next = scan_issue;
                cmp_idx_next   = issue_cnt_reg[IDX_BITS-1:0];
                if (scan_issue)
                begin
                    issue_cnt_next = issue_cnt_reg + CNT_BITS'(1);
                end
                if (cmp_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - IDX_BITS'(1);
                    wr_data = rd_data_reg;
                end
                if (!scan_issue && !cmp_valid_reg)
                begin
                    used_count_next = used_count_reg - CNT_BITS'(1);
                    state_next      = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.hit         = found_reg;
                    rsp_next.read_value  = res_value_reg;
                    rsp_next.full_error  = res_full_reg;
                    rsp_next.entry_count = used_count_reg;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            cmp_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            cmp_valid_reg  <= cmp_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        issue_cnt_reg   <= issue_cnt_next;
        cmp_idx_reg     <= cmp_idx_next;
        found_reg       <= found_next;
        pos_reg         <= pos_next;
        found_value_reg <= found_value_next;
        res_value_reg   <= res_value_next;
        res_full_reg    <= res_full_next;
        rsp_reg         <= rsp_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_count_reg <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RESOLVE && state_reg != ST_SHIFT) |=> $stable(used_count_reg))
        else $error("entry count changed outside update states");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.full_error) |-> !rsp.hit)
        else $error("full flag on a hitting request");

    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.read_value != '0) |-> rsp.hit)
        else $error("read value without hit");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_RESOLVE || state_reg == ST_SHIFT))
        else $error("table write outside update states");

endmodule
